>>> design/gtg_pkg.sv
// Package for the Greek to Greeklish transliterator.
// Holds character codes, the transliteration table and the queue entry type.
// No dependencies.
package gtg_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ENTRY_BYTES = 4;

  localparam logic [7:0] ACCENT_MARK    = 8'd39;
  localparam logic [7:0] DIAERESIS_MARK = 8'd34;

  // Greek letters that are held back for one item (mu, nu) and the letters that pair with them (pi, tau)
  localparam logic [7:0] CODE_CAP_MU  = 8'd204;
  localparam logic [7:0] CODE_CAP_NU  = 8'd205;
  localparam logic [7:0] CODE_LOW_MU  = 8'd236;
  localparam logic [7:0] CODE_LOW_NU  = 8'd237;
  localparam logic [7:0] CODE_CAP_PI  = 8'd208;
  localparam logic [7:0] CODE_LOW_PI  = 8'd240;
  localparam logic [7:0] CODE_CAP_TAU = 8'd212;
  localparam logic [7:0] CODE_LOW_TAU = 8'd244;

  localparam logic [7:0] CAPS_MAP [25] = '{
    "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K", "L", "M", "N",
    "K", "O", "P", "R", "x", "S", "T", "Y", "F", "X", "P", "W"
  };
  localparam logic [7:0] LOWS_MAP [25] = '{
    "a", "v", "g", "d", "e", "z", "h", "8", "i", "k", "l", "m", "n",
    "k", "o", "p", "r", "s", "s", "t", "y", "f", "x", "p", "w"
  };

  typedef struct packed {
    logic [2:0][7:0] e;
  } lut_t;

  typedef struct packed {
    logic [ENTRY_BYTES-1:0][7:0] bytes;
    logic [2:0]                  cnt;
  } entry_t;

  // Up to three output bytes per code, unused ones zero; e[0] is zero only for code 0.
  function automatic lut_t lookup(input logic [7:0] c);
    lut_t       r;
    logic [7:0] off_caps;
    logic [7:0] off_lows;
    off_caps = c - 8'd193;
    off_lows = c - 8'd225;
    r.e[0] = c;
    r.e[1] = 8'd0;
    r.e[2] = 8'd0;
    if ((c inside {[8'd193:8'd217]}) && (c != 8'd210)) begin
      r.e[0] = CAPS_MAP[off_caps[4:0]];
    end else if (c inside {[8'd225:8'd249]}) begin
      r.e[0] = LOWS_MAP[off_lows[4:0]];
    end
    case (c)
      8'd206, 8'd216: r.e[1] = "S";
      8'd238, 8'd248: r.e[1] = "s";
      8'd182: begin r.e[0] = ACCENT_MARK; r.e[1] = "A"; end
      8'd184: begin r.e[0] = ACCENT_MARK; r.e[1] = "E"; end
      8'd185: begin r.e[0] = ACCENT_MARK; r.e[1] = "H"; end
      8'd186: begin r.e[0] = ACCENT_MARK; r.e[1] = "I"; end
      8'd188: begin r.e[0] = ACCENT_MARK; r.e[1] = "O"; end
      8'd190: begin r.e[0] = ACCENT_MARK; r.e[1] = "Y"; end
      8'd191: begin r.e[0] = ACCENT_MARK; r.e[1] = "W"; end
      8'd220: begin r.e[0] = "a"; r.e[1] = ACCENT_MARK; end
      8'd221: begin r.e[0] = "e"; r.e[1] = ACCENT_MARK; end
      8'd222: begin r.e[0] = "h"; r.e[1] = ACCENT_MARK; end
      8'd223: begin r.e[0] = "i"; r.e[1] = ACCENT_MARK; end
      8'd252: begin r.e[0] = "o"; r.e[1] = ACCENT_MARK; end
      8'd253: begin r.e[0] = "y"; r.e[1] = ACCENT_MARK; end
      8'd254: begin r.e[0] = "w"; r.e[1] = ACCENT_MARK; end
      8'd218: begin r.e[0] = "I"; r.e[1] = DIAERESIS_MARK; end
      8'd219: begin r.e[0] = "Y"; r.e[1] = DIAERESIS_MARK; end
      8'd250: begin r.e[0] = "i"; r.e[1] = DIAERESIS_MARK; end
      8'd251: begin r.e[0] = "y"; r.e[1] = DIAERESIS_MARK; end
      8'd192: begin r.e[0] = "i"; r.e[1] = ACCENT_MARK; r.e[2] = DIAERESIS_MARK; end
      8'd224: begin r.e[0] = "y"; r.e[1] = ACCENT_MARK; r.e[2] = DIAERESIS_MARK; end
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> design/gtg_if.sv
// Stream interfaces for the transliterator: input bytes and output bytes.
// Depends on nothing.
interface gtg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface gtg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> design/greek_to_greeklish_transliterator_core.sv
// Greek (ISO-8859-7) to Greeklish transliterator, one input byte per item.
// Each item's entry is written to the entry queue, then loaded into the back end's
// entry register before its first output byte is valid. Output: one byte per cycle
// while out_o.ready is high; an item yields 0 to 4 bytes over the single byte port.
// Reset: asynchronous, clears the held letter, the entry queue and output valid.
module greek_to_greeklish_transliterator_core #(
  parameter int unsigned QDepth = gtg_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gtg_in_if.sink     in_i,
  gtg_out_if.source  out_o
);

  logic            push, pop, full, empty;
  gtg_pkg::entry_t entry, head;

  gtg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  gtg_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  gtg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> design/gtg_front.sv
// Front end: accepts input bytes, tracks the held M/N letter and builds
// a queue entry of up to four output bytes. Depends on gtg_pkg, gtg_if.
module gtg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  gtg_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output gtg_pkg::entry_t  entry_o
);

  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_CAP_M,
    PEND_CAP_N,
    PEND_LOW_M,
    PEND_LOW_N
  } pend_e;

  pend_e            pend_q, pend_d;
  logic             accept;
  logic             held;
  logic [7:0]       held_byte;
  logic             pair_m, pair_n;
  logic [7:0]       pair_byte;
  logic             holdable;
  gtg_pkg::lut_t    lk;
  gtg_pkg::lut_t    own;
  logic [2:0]       own_cnt;
  gtg_pkg::entry_t  ent;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    held      = 1'b1;
    held_byte = 8'd0;
    pair_m    = 1'b0;
    pair_n    = 1'b0;
    case (pend_q)
      PEND_CAP_M: held_byte = "M";
      PEND_CAP_N: held_byte = "N";
      PEND_LOW_M: held_byte = "m";
      PEND_LOW_N: held_byte = "n";
      default:    held      = 1'b0;
    endcase
    if (pend_q == PEND_CAP_M || pend_q == PEND_LOW_M) begin
      pair_m = (in_i.in_byte == gtg_pkg::CODE_CAP_PI) ||
               (in_i.in_byte == gtg_pkg::CODE_LOW_PI);
    end
    if (pend_q == PEND_CAP_N || pend_q == PEND_LOW_N) begin
      pair_n = (in_i.in_byte == gtg_pkg::CODE_CAP_TAU) ||
               (in_i.in_byte == gtg_pkg::CODE_LOW_TAU);
    end
    // case of B/D follows the held letter
    case (pend_q)
      PEND_CAP_M: pair_byte = "B";
      PEND_CAP_N: pair_byte = "D";
      PEND_LOW_M: pair_byte = "b";
      default:    pair_byte = "d";
    endcase

    lk       = gtg_pkg::lookup(in_i.in_byte);
    holdable = 1'b1;
    case (in_i.in_byte)
      gtg_pkg::CODE_CAP_MU: pend_d = PEND_CAP_M;
      gtg_pkg::CODE_CAP_NU: pend_d = PEND_CAP_N;
      gtg_pkg::CODE_LOW_MU: pend_d = PEND_LOW_M;
      gtg_pkg::CODE_LOW_NU: pend_d = PEND_LOW_N;
      default: begin
        pend_d   = PEND_NONE;
        holdable = 1'b0;
      end
    endcase
    own     = holdable ? '0 : lk;
    own_cnt = 3'(own.e[0] != 8'd0) + 3'(own.e[1] != 8'd0) + 3'(own.e[2] != 8'd0);

    if (pair_m || pair_n) begin
      pend_d    = PEND_NONE;
      ent.bytes = {24'd0, pair_byte};
      ent.cnt   = 3'd1;
    end else if (held) begin
      ent.bytes = {own.e[2], own.e[1], own.e[0], held_byte};
      ent.cnt   = own_cnt + 3'd1;
    end else begin
      ent.bytes = {8'd0, own.e[2], own.e[1], own.e[0]};
      ent.cnt   = own_cnt;
    end
  end

  assign entry_o = ent;
  assign push_o  = accept && (ent.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

>>> design/gtg_queue.sv
// Short entry queue between front and back ends.
// Depends on gtg_pkg.
module gtg_queue #(
  parameter int unsigned QDepth = gtg_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gtg_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output gtg_pkg::entry_t  head_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  gtg_pkg::entry_t mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth)) else $error("queue count out of range");
  a_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> entry_i.cnt != 3'd0 && entry_i.cnt <= 3'd4)
    else $error("entry byte count out of range");
`endif

endmodule

>>> design/gtg_back.sv
// Back end: takes entries from the queue and sends their bytes one per cycle
// while out_o.ready is high, flagging the final byte of each entry. Depends on gtg_pkg, gtg_if.
module gtg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gtg_pkg::entry_t  head_i,
  input  logic             empty_i,
  output logic             pop_o,
  gtg_out_if.source        out_o
);

  gtg_pkg::entry_t ent_q;
  logic [1:0]      idx_q;
  logic            busy_q;
  logic            fire, done, take;
  logic            is_last;

  assign is_last = ({1'b0, idx_q} + 3'd1) == ent_q.cnt;
  assign fire    = out_o.valid && out_o.ready;
  assign done    = fire && is_last;
  assign take    = (!busy_q || done) && !empty_i;
  assign pop_o   = take;

  assign out_o.valid       = busy_q;
  assign out_o.out_byte    = ent_q.bytes[idx_q];
  assign out_o.last_of_run = is_last;

  always_ff @(posedge clk_i) begin
    if (take) begin
      ent_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (fire) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> {1'b0, idx_q} < ent_q.cnt) else $error("byte index past entry");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.out_byte))
    else $error("output changed while stalled");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |-> !pop_o) else $error("pop while entry in progress");
`endif

endmodule
